// ----- rtl/qio_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qio_pkg
// Types, constants and the arctangent table shared by the odometry block.
// ---------------------------------------------------------------------------
package qio_pkg;

    localparam int ATAN_LEN = 24;

    localparam logic [23:0]       MPC_RESET   = 24'd562210;
    localparam logic signed [19:0] PI_Q16     = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [16:0] HEADING_MAX = 17'sd25736;
    localparam logic signed [30:0] GAIN_Q30   = 31'sd652032874;

    localparam logic CFG_MPC_X = 1'b0;
    localparam logic CFG_MPC_Y = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_SETUP_VEC,
        ST_VEC,
        ST_HEAD,
        ST_GAIN,
        ST_SETUP_ROT,
        ST_ROT,
        ST_FINISH
    } qio_state_t;

    typedef struct packed {
        logic       capture;
        logic       mult;
        logic       setup_vec;
        logic       iterate;
        logic       head;
        logic       gain;
        logic       setup_rot;
        logic       finish;
        logic [4:0] iter;
    } qio_cmd_t;

    typedef struct packed {
        logic out_free;
    } qio_status_t;

    function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
        logic signed [19:0] r;
        unique case (i)
            5'd0:    r = 20'sd51472;
            5'd1:    r = 20'sd30386;
            5'd2:    r = 20'sd16055;
            5'd3:    r = 20'sd8150;
            5'd4:    r = 20'sd4091;
            5'd5:    r = 20'sd2047;
            5'd6:    r = 20'sd1024;
            5'd7:    r = 20'sd512;
            5'd8:    r = 20'sd256;
            5'd9:    r = 20'sd128;
            5'd10:   r = 20'sd64;
            5'd11:   r = 20'sd32;
            5'd12:   r = 20'sd16;
            5'd13:   r = 20'sd8;
            5'd14:   r = 20'sd4;
            5'd15:   r = 20'sd2;
            5'd16:   r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/quadrature_imu_odometry.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted item runs through multiply, vectoring, heading, gain, rotation and finish
// before m_valid; s_ready is high only in idle, so a new item is taken only once the last
// is done, the single shared CORDIC unit running vectoring then rotation one step a cycle.
// A finished result waits in the output register while the next item runs.
// Reset (aresetn low, synchronous): counts and positions clear, scales reload.
// ---------------------------------------------------------------------------
// quadrature_imu_odometry
// Encoder plus IMU dead-reckoning: heading by CORDIC, rotated step, position.
// ---------------------------------------------------------------------------
module quadrature_imu_odometry import qio_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_we,
    input  wire                 cfg_addr,
    input  wire  [23:0]         cfg_wdata,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [15:0]         s_count_x,
    input  wire  [15:0]         s_count_y,
    input  wire  signed [15:0]  s_quat_w,
    input  wire  signed [15:0]  s_quat_x,
    input  wire  signed [15:0]  s_quat_y,
    input  wire  signed [15:0]  s_quat_z,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [15:0]  m_heading,
    output logic signed [23:0]  m_step_x,
    output logic signed [23:0]  m_step_y,
    output logic signed [31:0]  m_position_x,
    output logic signed [31:0]  m_position_y
);

    qio_cmd_t    cmd;
    qio_status_t status;

    qio_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qio_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_count_x    (s_count_x),
        .s_count_y    (s_count_y),
        .s_quat_w     (s_quat_w),
        .s_quat_x     (s_quat_x),
        .s_quat_y     (s_quat_y),
        .s_quat_z     (s_quat_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_heading    (m_heading),
        .m_step_x     (m_step_x),
        .m_step_y     (m_step_y),
        .m_position_x (m_position_x),
        .m_position_y (m_position_y)
    );

endmodule
`default_nettype wire

// ----- rtl/qio_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qio_ctrl
// Sequencer: walks one item through multiply, vectoring CORDIC, heading,
// gain scaling, rotation CORDIC and accumulation.
// ---------------------------------------------------------------------------
module qio_ctrl import qio_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  qio_status_t  status,
    output qio_cmd_t     cmd
);

    localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [4:0] LAST_ITER = 5'(STEPS - 1);

    qio_state_t state_reg, state_next;
    logic [4:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.iter   = iter_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_SETUP_VEC;
            end
            ST_SETUP_VEC: begin
                cmd.setup_vec = 1'b1;
                iter_next     = '0;
                state_next    = ST_VEC;
            end
            ST_VEC: begin
                cmd.iterate = 1'b1;
                iter_next   = iter_reg + 5'd1;
                if (iter_reg == LAST_ITER) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cmd.head   = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_SETUP_ROT;
            end
            ST_SETUP_ROT: begin
                cmd.setup_rot = 1'b1;
                iter_next     = '0;
                state_next    = ST_ROT;
            end
            ST_ROT: begin
                cmd.iterate = 1'b1;
                iter_next   = iter_reg + 5'd1;
                if (iter_reg == LAST_ITER) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/qio_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qio_datapath
// Delta and scale, quaternion terms, shared CORDIC unit, saturating
// accumulators and the output register.
// ---------------------------------------------------------------------------
module qio_datapath import qio_pkg::*; (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  qio_cmd_t            cmd,
    output qio_status_t         status,
    input  wire                 cfg_we,
    input  wire                 cfg_addr,
    input  wire  [23:0]         cfg_wdata,
    input  wire  [15:0]         s_count_x,
    input  wire  [15:0]         s_count_y,
    input  wire  signed [15:0]  s_quat_w,
    input  wire  signed [15:0]  s_quat_x,
    input  wire  signed [15:0]  s_quat_y,
    input  wire  signed [15:0]  s_quat_z,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [15:0]  m_heading,
    output logic signed [23:0]  m_step_x,
    output logic signed [23:0]  m_step_y,
    output logic signed [31:0]  m_position_x,
    output logic signed [31:0]  m_position_y
);

    logic [23:0] mpc_x_reg, mpc_y_reg;
    logic [15:0] last_x_reg, last_y_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] wz_reg, xy_reg, yy_reg, zz_reg;
    logic signed [40:0] mx_reg, my_reg;
    logic signed [25:0] bx_reg, by_reg;
    logic signed [56:0] gx_reg, gy_reg;
    logic signed [42:0] x_reg, y_reg;
    logic signed [19:0] z_reg;
    logic               vec_reg, null_reg;
    logic signed [15:0] head_reg;
    logic               m_valid_reg;
    logic signed [15:0] out_head_reg;
    logic signed [23:0] out_sx_reg, out_sy_reg;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpc_x_reg <= MPC_RESET;
            mpc_y_reg <= MPC_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MPC_X: mpc_x_reg <= cfg_wdata;
                CFG_MPC_Y: mpc_y_reg <= cfg_wdata;
                default:   mpc_x_reg <= mpc_x_reg;
            endcase
        end
    end

    // vectoring setup
    logic signed [33:0] s_val, c_val;
    logic signed [41:0] bx_sum, by_sum;
    always_comb begin
        s_val  = (34'(wz_reg) + 34'(xy_reg)) <<< 1;
        c_val  = 34'sd268435456 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1);
        bx_sum = 42'(mx_reg) + 42'sd32768;
        by_sum = 42'(my_reg) + 42'sd32768;
    end

    // shared CORDIC step
    logic               neg_dir;
    logic signed [42:0] x_sh, y_sh;
    logic signed [19:0] atan_i;
    always_comb begin
        neg_dir = vec_reg ? !y_reg[42] : z_reg[19];
        x_sh    = x_reg >>> cmd.iter;
        y_sh    = y_reg >>> cmd.iter;
        atan_i  = atan_q16(cmd.iter);
    end

    // heading
    logic signed [16:0] h_round;
    logic signed [15:0] h_clamp;
    always_comb begin
        h_round = 17'((21'(z_reg) + 21'sd4) >>> 3);
        if (null_reg) begin
            h_clamp = '0;
        end else if (h_round > HEADING_MAX) begin
            h_clamp = 16'(HEADING_MAX);
        end else if (h_round < -HEADING_MAX) begin
            h_clamp = 16'(-HEADING_MAX);
        end else begin
            h_clamp = h_round[15:0];
        end
    end

    // rotation setup
    logic signed [19:0] zrot;
    logic signed [42:0] gx, gy;
    always_comb begin
        zrot = 20'(head_reg) <<< 3;
        gx   = gx_reg[56:14];
        gy   = gy_reg[56:14];
    end

    // finish: round, clamp, accumulate
    logic signed [43:0] rx_sum, ry_sum;
    logic signed [27:0] rx, ry;
    logic signed [23:0] sx, sy;
    logic signed [32:0] px_sum, py_sum;
    logic signed [31:0] px, py;
    always_comb begin
        rx_sum = 44'(x_reg) + 44'sd32768;
        ry_sum = 44'(y_reg) + 44'sd32768;
        rx     = rx_sum[43:16];
        ry     = ry_sum[43:16];
        if (rx > 28'sd8388607)       sx = 24'sh7FFFFF;
        else if (rx < -28'sd8388608) sx = 24'sh800000;
        else                         sx = rx[23:0];
        if (ry > 28'sd8388607)       sy = 24'sh7FFFFF;
        else if (ry < -28'sd8388608) sy = 24'sh800000;
        else                         sy = ry[23:0];
        px_sum = 33'(pos_x_reg) + 33'(sx);
        py_sum = 33'(pos_y_reg) + 33'(sy);
        if (px_sum[32] != px_sum[31]) px = px_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else                          px = px_sum[31:0];
        if (py_sum[32] != py_sum[31]) py = py_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else                          py = py_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                last_x_reg <= s_count_x;
                last_y_reg <= s_count_y;
            end
            if (cmd.finish) begin
                pos_x_reg   <= px;
                pos_y_reg   <= py;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dx_reg <= signed'(s_count_x - last_x_reg);
            dy_reg <= signed'(s_count_y - last_y_reg);
            qw_reg <= s_quat_w;
            qx_reg <= s_quat_x;
            qy_reg <= s_quat_y;
            qz_reg <= s_quat_z;
        end
        if (cmd.mult) begin
            wz_reg <= qw_reg * qz_reg;
            xy_reg <= qx_reg * qy_reg;
            yy_reg <= qy_reg * qy_reg;
            zz_reg <= qz_reg * qz_reg;
            mx_reg <= 41'(dx_reg) * 41'(signed'({1'b0, mpc_x_reg}));
            my_reg <= 41'(dy_reg) * 41'(signed'({1'b0, mpc_y_reg}));
        end
        if (cmd.setup_vec) begin
            bx_reg   <= bx_sum[41:16];
            by_reg   <= by_sum[41:16];
            vec_reg  <= 1'b1;
            null_reg <= (s_val == '0) && (c_val == '0);
            if (c_val[33]) begin
                x_reg <= -43'(c_val);
                y_reg <= -43'(s_val);
                z_reg <= s_val[33] ? -PI_Q16 : PI_Q16;
            end else begin
                x_reg <= 43'(c_val);
                y_reg <= 43'(s_val);
                z_reg <= '0;
            end
        end
        if (cmd.iterate) begin
            if (neg_dir) begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_i;
            end else begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_i;
            end
        end
        if (cmd.head) begin
            head_reg <= h_clamp;
        end
        if (cmd.gain) begin
            gx_reg <= 57'(bx_reg) * 57'(GAIN_Q30);
            gy_reg <= 57'(by_reg) * 57'(GAIN_Q30);
        end
        if (cmd.setup_rot) begin
            vec_reg <= 1'b0;
            // fold into the right half plane
            if (zrot > HALF_PI_Q16) begin
                x_reg <= -gx;
                y_reg <= -gy;
                z_reg <= zrot - PI_Q16;
            end else if (zrot < -HALF_PI_Q16) begin
                x_reg <= -gx;
                y_reg <= -gy;
                z_reg <= zrot + PI_Q16;
            end else begin
                x_reg <= gx;
                y_reg <= gy;
                z_reg <= zrot;
            end
        end
        if (cmd.finish) begin
            out_head_reg <= head_reg;
            out_sx_reg   <= sx;
            out_sy_reg   <= sy;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_heading    = out_head_reg;
    assign m_step_x     = out_sx_reg;
    assign m_step_y     = out_sy_reg;
    assign m_position_x = pos_x_reg;
    assign m_position_y = pos_y_reg;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Odometry block testbench
// Drives encoder counts and quaternions through the valid/ready channels,
// predicts heading, rotated step and saturated position per tick, and
// compares every result in order against the prediction or a row's given value.
// ---------------------------------------------------------------------------
module testbench;
    import qio_pkg::*;

    localparam int  ITERS      = 16;
    localparam longint PI_ANG  = 205887;
    localparam longint HALF_PI = 102944;
    localparam longint HEAD_LIM = 25736;
    localparam longint GAIN    = 652032874;
    localparam longint STEP_HI = 8388607;
    localparam longint STEP_LO = -8388608;
    localparam longint POS_HI  = 2147483647;
    localparam longint POS_LO  = -64'sd2147483648;
    localparam int  QUIET_LIMIT = 4000;

    localparam longint ANGLE_STEP [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    typedef struct {
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } tick_t;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [23:0] step_x;
        logic signed [23:0] step_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } odo_t;

    typedef struct {
        tick_t s;
        bit    typed;
        odo_t  want;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_addr = 1'b0;
    logic [23:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic [15:0]        s_count_x = '0;
    logic [15:0]        s_count_y = '0;
    logic signed [15:0] s_quat_w = '0;
    logic signed [15:0] s_quat_x = '0;
    logic signed [15:0] s_quat_y = '0;
    logic signed [15:0] s_quat_z = '0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire signed [15:0]  m_heading;
    wire signed [23:0]  m_step_x;
    wire signed [23:0]  m_step_y;
    wire signed [31:0]  m_position_x;
    wire signed [31:0]  m_position_y;

    quadrature_imu_odometry dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_count_x(s_count_x), .s_count_y(s_count_y),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_heading(m_heading), .m_step_x(m_step_x), .m_step_y(m_step_y),
        .m_position_x(m_position_x), .m_position_y(m_position_y)
    );

    // odometry state mirrored from the block
    logic [23:0]  scale_x = MPC_RESET;
    logic [23:0]  scale_y = MPC_RESET;
    logic [15:0]  prev_cx = '0;
    logic [15:0]  prev_cy = '0;
    longint       acc_x = 0;
    longint       acc_y = 0;

    odo_t         pending_ticks [$];
    bit           failed = 1'b0;
    int unsigned  cyc = 0;
    int unsigned  quiet = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cyc <= cyc + 1;

    // no idling on either side inside this window
    function automatic bit calm();
        return cyc >= 9000 && cyc < 16000;
    endfunction

    function automatic bit holdoff();
        return cyc >= 3000 && cyc < 3400;
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint yaw_angle(longint s, longint c);
        longint x, y, z, t;
        if (s == 0 && c == 0) return 0;
        x = c; y = s; z = 0;
        if (c < 0) begin
            x = -c; y = -s;
            z = (s >= 0) ? PI_ANG : -PI_ANG;
        end
        for (int i = 0; i < ITERS; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + (y >>> i); y = y - (t >>> i); z += ANGLE_STEP[i];
            end else begin
                x = x - (y >>> i); y = y + (t >>> i); z -= ANGLE_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic odo_t advance_odometry(tick_t st);
        odo_t r;
        logic signed [15:0] dx16, dy16;
        longint bx, by, s, c, h, x, y, z, t, fx, fy;
        dx16 = st.cx - prev_cx;
        dy16 = st.cy - prev_cy;
        prev_cx = st.cx;
        prev_cy = st.cy;
        bx = rnd_shift(longint'(dx16) * longint'(scale_x), 16);
        by = rnd_shift(longint'(dy16) * longint'(scale_y), 16);
        s = 2 * (longint'(st.qw) * st.qz + longint'(st.qx) * st.qy);
        c = (longint'(1) << 28) - 2 * (longint'(st.qy) * st.qy + longint'(st.qz) * st.qz);
        h = clip(rnd_shift(yaw_angle(s, c), 3), -HEAD_LIM, HEAD_LIM);
        // rotate the gain-compensated body step by the heading
        x = (bx * GAIN) >>> 14;
        y = (by * GAIN) >>> 14;
        z = h * 8;
        if (z > HALF_PI) begin
            x = -x; y = -y; z -= PI_ANG;
        end else if (z < -HALF_PI) begin
            x = -x; y = -y; z += PI_ANG;
        end
        for (int i = 0; i < ITERS; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - (y >>> i); y = y + (t >>> i); z -= ANGLE_STEP[i];
            end else begin
                x = x + (y >>> i); y = y - (t >>> i); z += ANGLE_STEP[i];
            end
        end
        fx = clip(rnd_shift(x, 16), STEP_LO, STEP_HI);
        fy = clip(rnd_shift(y, 16), STEP_LO, STEP_HI);
        acc_x = clip(acc_x + fx, POS_LO, POS_HI);
        acc_y = clip(acc_y + fy, POS_LO, POS_HI);
        r.heading = h[15:0];
        r.step_x  = fx[23:0];
        r.step_y  = fy[23:0];
        r.pos_x   = acc_x[31:0];
        r.pos_y   = acc_y[31:0];
        return r;
    endfunction

    task automatic send_tick(tick_t st, bit typed, odo_t want);
        odo_t pred;
        @(negedge aclk);
        if (!calm() && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_count_x <= st.cx;
        s_count_y <= st.cy;
        s_quat_w  <= st.qw;
        s_quat_x  <= st.qx;
        s_quat_y  <= st.qy;
        s_quat_z  <= st.qz;
        do @(posedge aclk); while (!s_ready);
        pred = advance_odometry(st);
        pending_ticks.push_back(typed ? want : pred);
    endtask

    // drop valid and let every outstanding result come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_scale(logic addr, logic [23:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (addr == CFG_MPC_X) scale_x = val;
        else scale_y = val;
    endtask

    function automatic logic signed [15:0] rand_quat();
        if ($urandom_range(99) < 15) return 16'($urandom);
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    task automatic random_ticks(int n);
        tick_t st;
        odo_t  none;
        none = '{default: '0};
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                st.cx = prev_cx + 16'(int'($urandom_range(4000)) - 2000);
                st.cy = prev_cy + 16'(int'($urandom_range(4000)) - 2000);
            end else begin
                st.cx = 16'($urandom);
                st.cy = 16'($urandom);
            end
            st.qw = rand_quat();
            st.qx = rand_quat();
            st.qy = rand_quat();
            st.qz = rand_quat();
            send_tick(st, 1'b0, none);
        end
    endtask

    // large steps at zero heading to drive both accumulators into saturation
    task automatic ramp_ticks(int n, logic [15:0] stride);
        tick_t st;
        odo_t  none;
        none = '{default: '0};
        for (int k = 0; k < n; k++) begin
            st = '{prev_cx + stride, prev_cy + stride, 16384, 0, 0, 0};
            send_tick(st, 1'b0, none);
        end
    endtask

    // receiver side
    always @(negedge aclk) begin
        if (holdoff()) m_ready <= 1'b0;
        else if (calm()) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 36);
    end

    task automatic check_field(string name, longint exp, longint got);
        if (exp != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        odo_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ticks.size() == 0) begin
                $display("%0t unexpected result: heading %0d", $time, m_heading);
                failed = 1'b1;
            end else begin
                w = pending_ticks.pop_front();
                check_field("heading", w.heading, m_heading);
                check_field("step_x", w.step_x, m_step_x);
                check_field("step_y", w.step_y, m_step_y);
                check_field("position_x", w.pos_x, m_position_x);
                check_field("position_y", w.pos_y, m_position_y);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        row_t  plan [$];
        odo_t  zero;
        zero = '{default: '0};
        plan.push_back('{'{16'h0000, 16'h0000, 16384, 0, 0, 0}, 1'b1, zero});
        // null heading vector: both atan2 arguments cancel
        plan.push_back('{'{16'h0000, 16'h0000, 0, 0, 8192, 8192}, 1'b1, zero});
        plan.push_back('{'{16'hFFFF, 16'hFFFF, 16384, 0, 0, 0}, 1'b0, zero});
        plan.push_back('{'{16'h7FFF, 16'h7FFF, 16384, 0, 0, 0}, 1'b0, zero});
        plan.push_back('{'{16'hFFFF, 16'h0000, 16384, 0, 0, 0}, 1'b0, zero});
        plan.push_back('{'{16'h8000, 16'h7FFF, 11585, 0, 0, 11585}, 1'b0, zero});
        plan.push_back('{'{16'h8100, 16'h8000, 0, 0, 0, 16384}, 1'b0, zero});
        plan.push_back('{'{16'h8200, 16'h8050, 11585, 0, 0, -11585}, 1'b0, zero});
        plan.push_back('{'{16'h8000, 16'h8100, -16384, 0, 0, 0}, 1'b0, zero});
        plan.push_back('{'{16'h0100, 16'h0200, 16384, 16384, 16384, 16384}, 1'b0, zero});
        plan.push_back('{'{16'h0400, 16'h0000, -32768, -32768, 32767, -32768},
                        1'b0, zero});
        plan.push_back('{'{16'h0500, 16'h0100, 0, 16384, 0, 0}, 1'b0, zero});
        plan.push_back('{'{16'h0600, 16'h0200, 0, 0, 16384, 0}, 1'b0, zero});
        plan.push_back('{'{16'h0700, 16'h0300, 1, 0, 0, -16384}, 1'b0, zero});
        plan.push_back('{'{16'h0710, 16'h0310, 0, 0, -16384, 1}, 1'b0, zero});
        plan.push_back('{'{16'hAAAA, 16'h5555, 32767, -16384, 16384, -1}, 1'b0, zero});
        plan.push_back('{'{16'h5555, 16'hAAAA, -1, 32767, -32768, 16384}, 1'b0, zero});
        plan.push_back('{'{16'h5556, 16'hAAA9, 16384, 0, 0, 0}, 1'b0, zero});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_tick(plan[i].s, plan[i].typed, plan[i].want);
        random_ticks(60);

        drain();
        write_scale(CFG_MPC_X, 24'hFFFFFF);
        write_scale(CFG_MPC_Y, 24'hFFFFFF);
        ramp_ticks(280, 16'h7FFF);
        ramp_ticks(560, 16'h8000);
        random_ticks(100);

        drain();
        write_scale(CFG_MPC_X, 24'h000000);
        random_ticks(170);

        drain();
        write_scale(CFG_MPC_X, 24'($urandom));
        write_scale(CFG_MPC_Y, 24'($urandom));
        random_ticks(220);

        drain();
        write_scale(CFG_MPC_X, MPC_RESET);
        write_scale(CFG_MPC_Y, 24'h000001);
        random_ticks(200);

        drain();
        repeat (60) @(posedge aclk);
        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
